// ===== hdl/ghp_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants for the generational handle pool.
package ghp_pkg;

  localparam int unsigned SLOTS  = 256;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned GEN_W  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned TAG_W  = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_MAKE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_OUT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_FIX,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [TAG_W-1:0]  handle_type;
    logic [IDX_W-1:0]  handle_index;
    logic [GEN_W-1:0]  handle_generation;
    logic [IDX_W-1:0]  dense_position;
    logic              has_object;
    logic [DATA_W-1:0] object_word;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [TAG_W-1:0]  out_type;
    logic [IDX_W-1:0]  out_slot;
    logic [GEN_W-1:0]  out_generation;
    logic [IDX_W-1:0]  out_position;
    logic [DATA_W-1:0] out_data;
  } rsp_t;

endpackage

// ===== hdl/generational_handle_pool_unit.sv =====
`timescale 1ns / 1ps
// Generational handle pool: slot table and dense store in synchronous memories.
//
//  channel  direction  handshake                 payload
//  cfg      in         cfg_valid_i / cfg_ready_o  cfg_pool_tag_i
//  in       in         in_valid_i / in_ready_o    in_req_i (req_t)
//  out      out        out_valid_o / out_ready_i  out_rsp_o (rsp_t)
//
// Insert and rejected requests pass S_RD1 then S_OUT, lookup and make-handle add S_RD2,
// and remove adds S_FIX when the last dense entry moves into the hole; each memory
// read is registered and the link table has one write port, which sets these steps.
// One request is in work at a time; a finished response waits in the output
// register while the next request is taken. Reset clears counters, free-list
// head and occupancy bits; memory entries are written before they are read.
module generational_handle_pool_unit
  import ghp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [TAG_W-1:0] cfg_pool_tag_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_rsp_o
);

  logic [CNT_W-1:0]  slot_link_mem   [SLOTS];
  logic [GEN_W-1:0]  slot_gen_mem    [SLOTS];
  logic [IDX_W-1:0]  dense_owner_mem [SLOTS];
  logic [DATA_W-1:0] dense_data_mem  [SLOTS];

  state_e            state_q, state_d;
  req_t              req_q;
  rsp_t              res_q, res_d;
  rsp_t              out_q;
  logic              out_valid_q;
  logic [TAG_W-1:0]  pool_tag_q;
  logic [CNT_W-1:0]  free_head_q, free_head_d;
  logic [CNT_W-1:0]  slots_used_q, slots_used_d;
  logic [CNT_W-1:0]  dense_count_q, dense_count_d;
  logic [SLOTS-1:0]  slot_live_q;
  logic [IDX_W-1:0]  pos_q, pos_d;

  logic [CNT_W-1:0]  link_rd_q;
  logic [GEN_W-1:0]  gen_rd_q;
  logic [IDX_W-1:0]  a_owner_q, b_owner_q;
  logic [DATA_W-1:0] a_data_q, b_data_q;

  logic              accept;
  logic              slot_re, dense_re;
  logic [IDX_W-1:0]  slot_raddr, dense_raddr_a, dense_raddr_b;
  logic              link_we, gen_we, dense_we;
  logic [IDX_W-1:0]  link_waddr, gen_waddr, dense_waddr;
  logic [CNT_W-1:0]  link_wdata;
  logic [GEN_W-1:0]  gen_wdata;
  logic              live_set, live_clr;
  logic [IDX_W-1:0]  live_idx;
  logic              out_load;

  logic              has_free, full, handle_ok, moves;
  logic [IDX_W-1:0]  ins_slot;
  logic [CNT_W-1:0]  last;
  logic [DATA_W-1:0] word;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign has_free  = free_head_q < CNT_W'(SLOTS);
  assign full      = (!has_free && slots_used_q == CNT_W'(SLOTS))
                     || dense_count_q == CNT_W'(SLOTS);
  assign ins_slot  = has_free ? free_head_q[IDX_W-1:0] : slots_used_q[IDX_W-1:0];
  assign last      = dense_count_q - CNT_W'(1);
  assign moves     = pos_q != last[IDX_W-1:0];
  assign word      = req_q.has_object ? req_q.object_word : '0;
  assign handle_ok = req_q.handle_type == pool_tag_q
                     && {1'b0, req_q.handle_index} < slots_used_q
                     && slot_live_q[req_q.handle_index]
                     && gen_rd_q == req_q.handle_generation
                     && link_rd_q < dense_count_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RD1;
      end
      S_RD1: begin
        case (req_q.op)
          OP_INSERT: state_d = S_OUT;
          OP_MAKE:   state_d = ({1'b0, req_q.dense_position} < dense_count_q) ? S_RD2 : S_OUT;
          default:   state_d = handle_ok ? S_RD2 : S_OUT;
        endcase
      end
      S_RD2: begin
        state_d = (req_q.op == OP_REMOVE && moves) ? S_FIX : S_OUT;
      end
      S_FIX: state_d = S_OUT;
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d         = res_q;
    pos_d         = pos_q;
    free_head_d   = free_head_q;
    slots_used_d  = slots_used_q;
    dense_count_d = dense_count_q;
    slot_re       = 1'b0;
    dense_re      = 1'b0;
    slot_raddr    = req_q.handle_index;
    dense_raddr_a = in_req_i.dense_position;
    dense_raddr_b = last[IDX_W-1:0];
    link_we       = 1'b0;
    link_waddr    = ins_slot;
    link_wdata    = dense_count_q;
    gen_we        = 1'b0;
    gen_waddr     = ins_slot;
    gen_wdata     = '0;
    dense_we      = 1'b0;
    dense_waddr   = dense_count_q[IDX_W-1:0];
    live_set      = 1'b0;
    live_clr      = 1'b0;
    live_idx      = ins_slot;
    case (state_q)
      S_IDLE: begin
        slot_re    = accept;
        dense_re   = accept;
        slot_raddr = (in_req_i.op == OP_INSERT) ? free_head_q[IDX_W-1:0]
                                                : in_req_i.handle_index;
      end
      S_RD1: begin
        res_d = '0;
        case (req_q.op)
          OP_INSERT: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              link_we  = 1'b1;
              gen_we   = !has_free;
              dense_we = 1'b1;
              live_set = 1'b1;
              if (has_free) free_head_d = link_rd_q;
              else slots_used_d = slots_used_q + CNT_W'(1);
              dense_count_d = dense_count_q + CNT_W'(1);
              res_d = '{status: ST_OK, out_type: pool_tag_q, out_slot: ins_slot,
                        out_generation: has_free ? gen_rd_q : '0,
                        out_position: dense_count_q[IDX_W-1:0], out_data: word};
            end
          end
          OP_MAKE: begin
            if ({1'b0, req_q.dense_position} < dense_count_q) begin
              slot_re    = 1'b1;
              slot_raddr = a_owner_q;
            end else begin
              res_d.status = ST_OUT_RANGE;
            end
          end
          default: begin
            if (handle_ok) begin
              pos_d         = link_rd_q[IDX_W-1:0];
              dense_re      = 1'b1;
              dense_raddr_a = link_rd_q[IDX_W-1:0];
            end else begin
              res_d.status = ST_INVALID;
            end
          end
        endcase
      end
      S_RD2: begin
        if (req_q.op == OP_MAKE) begin
          res_d = '{status: ST_OK, out_type: pool_tag_q, out_slot: a_owner_q,
                    out_generation: gen_rd_q, out_position: req_q.dense_position,
                    out_data: a_data_q};
        end else begin
          res_d = '{status: ST_OK, out_type: req_q.handle_type,
                    out_slot: req_q.handle_index,
                    out_generation: req_q.handle_generation,
                    out_position: pos_q, out_data: a_data_q};
        end
        if (req_q.op == OP_REMOVE) begin
          gen_we        = 1'b1;
          gen_waddr     = req_q.handle_index;
          gen_wdata     = gen_rd_q + GEN_W'(1);
          link_we       = 1'b1;
          link_waddr    = req_q.handle_index;
          link_wdata    = free_head_q;
          live_clr      = 1'b1;
          live_idx      = req_q.handle_index;
          free_head_d   = {1'b0, req_q.handle_index};
          dense_count_d = last;
          dense_we      = moves;
          dense_waddr   = pos_q;
        end
      end
      S_FIX: begin
        link_we    = 1'b1;
        link_waddr = b_owner_q;
        link_wdata = {1'b0, pos_q};
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (link_we) slot_link_mem[link_waddr] <= link_wdata;
    if (gen_we) slot_gen_mem[gen_waddr] <= gen_wdata;
    if (slot_re) begin
      link_rd_q <= slot_link_mem[slot_raddr];
      gen_rd_q  <= slot_gen_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dense_we) begin
      dense_owner_mem[dense_waddr] <= (state_q == S_RD1) ? ins_slot : b_owner_q;
      dense_data_mem[dense_waddr]  <= (state_q == S_RD1) ? word : b_data_q;
    end
    if (dense_re) begin
      a_owner_q <= dense_owner_mem[dense_raddr_a];
      a_data_q  <= dense_data_mem[dense_raddr_a];
      b_owner_q <= dense_owner_mem[dense_raddr_b];
      b_data_q  <= dense_data_mem[dense_raddr_b];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
    res_q <= res_d;
    pos_q <= pos_d;
    if (out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      pool_tag_q    <= '0;
      free_head_q   <= CNT_W'(SLOTS);
      slots_used_q  <= '0;
      dense_count_q <= '0;
      slot_live_q   <= '0;
    end else begin
      state_q       <= state_d;
      free_head_q   <= free_head_d;
      slots_used_q  <= slots_used_d;
      dense_count_q <= dense_count_d;
      if (cfg_valid_i && cfg_ready_o) pool_tag_q <= cfg_pool_tag_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (live_set) slot_live_q[live_idx] <= 1'b1;
      if (live_clr) slot_live_q[live_idx] <= 1'b0;
    end
  end

endmodule

// ===== hdl/ghp_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the generational handle pool, bound to the top level.
module ghp_checker
  import ghp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input rsp_t             out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response dropped before taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("response changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |->
      out_rsp_o.out_type == '0 && out_rsp_o.out_slot == '0
      && out_rsp_o.out_generation == '0 && out_rsp_o.out_position == '0
      && out_rsp_o.out_data == '0)
    else $error("error response carries nonzero fields");

endmodule

bind generational_handle_pool_unit ghp_checker u_ghp_checker (.*);

// ===== verif/generational_handle_pool_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking regression of the generational handle pool against a slot-map predictor.
module generational_handle_pool_unit_test;
  import ghp_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DIR_N         = 21;
  localparam int PHASE_N       = 4;
  localparam int PHASE_ITEMS   = 300;
  localparam int REUSE_PAIRS   = 64;

  localparam int SEND_IDLE [PHASE_N] = '{0, 80, 0, 20};
  localparam int RECV_IDLE [PHASE_N] = '{0, 0, 80, 20};
  localparam int INS_PCT   [PHASE_N] = '{35, 20, 30, 20};

  localparam rsp_t R_NONE  = '0;
  localparam rsp_t R_INV   = '{status: ST_INVALID, default: '0};
  localparam rsp_t R_RANGE = '{status: ST_OUT_RANGE, default: '0};

  typedef struct packed {
    req_t req;
    logic fixed;
    rsp_t rsp;
  } dir_row_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [TAG_W-1:0] cfg_pool_tag_i = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  req_t             in_req_i       = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  rsp_t             out_rsp_o;

  // pool image
  logic [TAG_W-1:0]  pool_tag_q = '0;
  int unsigned       link_tab  [SLOTS];
  logic [GEN_W-1:0]  gen_tab   [SLOTS];
  bit                occupied  [SLOTS];
  logic [IDX_W-1:0]  owner_tab [SLOTS];
  logic [DATA_W-1:0] word_tab  [SLOTS];
  int unsigned       opened_cnt = 0;
  int unsigned       packed_cnt = 0;
  int unsigned       free_top   = SLOTS;

  rsp_t rsp_due [$];
  int   mismatches    = 0;
  int   quiet_cycles  = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;

  dir_row_t dir_tab [DIR_N] = '{
    '{'{OP_LOOKUP, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b1, R_INV},
    '{'{OP_MAKE,   16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b1, R_RANGE},
    '{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b1, R_INV},
    '{'{OP_INSERT, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b1, 32'hFFFF_FFFF}, 1'b1,
      '{ST_OK, 16'h0000, 8'h00, 16'h0000, 8'h00, 32'hFFFF_FFFF}},
    '{'{OP_INSERT, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 32'hDEAD_BEEF}, 1'b1,
      '{ST_OK, 16'h0000, 8'h01, 16'h0000, 8'h01, 32'h0000_0000}},
    '{'{OP_INSERT, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b1, 32'h1234_5678}, 1'b1,
      '{ST_OK, 16'h0000, 8'h02, 16'h0000, 8'h02, 32'h1234_5678}},
    '{'{OP_LOOKUP, 16'h0000, 8'h01, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b1,
      '{ST_OK, 16'h0000, 8'h01, 16'h0000, 8'h01, 32'h0000_0000}},
    '{'{OP_LOOKUP, 16'hFFFF, 8'h01, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b1, R_INV},
    '{'{OP_LOOKUP, 16'h0000, 8'h01, 16'hFFFF, 8'h00, 1'b0, 32'h0000_0000}, 1'b1, R_INV},
    '{'{OP_LOOKUP, 16'h0000, 8'hFF, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b1, R_INV},
    '{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b1,
      '{ST_OK, 16'h0000, 8'h00, 16'h0000, 8'h00, 32'hFFFF_FFFF}},
    // freed slot with its current generation
    '{'{OP_LOOKUP, 16'h0000, 8'h00, 16'h0001, 8'h00, 1'b0, 32'h0000_0000}, 1'b1, R_INV},
    '{'{OP_LOOKUP, 16'h0000, 8'h02, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b0, R_NONE},
    '{'{OP_MAKE,   16'h0000, 8'h00, 16'h0000, 8'h01, 1'b0, 32'h0000_0000}, 1'b0, R_NONE},
    '{'{OP_MAKE,   16'h0000, 8'h00, 16'h0000, 8'hFF, 1'b0, 32'h0000_0000}, 1'b1, R_RANGE},
    '{'{OP_INSERT, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b1, 32'hA5A5_5A5A}, 1'b0, R_NONE},
    '{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0001, 8'h00, 1'b0, 32'h0000_0000}, 1'b0, R_NONE},
    '{'{OP_REMOVE, 16'h0000, 8'h01, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b0, R_NONE},
    '{'{OP_REMOVE, 16'h0000, 8'h01, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b1, R_INV},
    '{'{OP_MAKE,   16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b0, R_NONE},
    '{'{OP_REMOVE, 16'h0000, 8'h02, 16'h0000, 8'h00, 1'b0, 32'h0000_0000}, 1'b0, R_NONE}
  };

  generational_handle_pool_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_pool_tag_i (cfg_pool_tag_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_req_i       (in_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_rsp_o      (out_rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic rsp_t pool_apply(input req_t r);
    rsp_t              rsp;
    int unsigned       s;
    int unsigned       p;
    int unsigned       last;
    int unsigned       mover;
    logic [DATA_W-1:0] word;
    rsp  = '0;
    word = r.has_object ? r.object_word : '0;
    s    = 32'(r.handle_index);
    case (r.op)
      OP_INSERT: begin
        if (free_top < SLOTS) begin
          s        = free_top;
          free_top = link_tab[s];
        end else if (opened_cnt < SLOTS) begin
          s          = opened_cnt;
          opened_cnt = opened_cnt + 1;
          gen_tab[s] = '0;
        end else begin
          rsp.status = ST_FULL;
          return rsp;
        end
        link_tab[s]           = packed_cnt;
        occupied[s]           = 1'b1;
        owner_tab[packed_cnt] = IDX_W'(s);
        word_tab[packed_cnt]  = word;
        rsp = '{ST_OK, pool_tag_q, IDX_W'(s), gen_tab[s], IDX_W'(packed_cnt), word};
        packed_cnt = packed_cnt + 1;
      end
      OP_REMOVE, OP_LOOKUP: begin
        if (r.handle_type != pool_tag_q || s >= opened_cnt || !occupied[s]
            || gen_tab[s] != r.handle_generation || link_tab[s] >= packed_cnt) begin
          rsp.status = ST_INVALID;
          return rsp;
        end
        p   = link_tab[s];
        rsp = '{ST_OK, r.handle_type, r.handle_index, r.handle_generation, IDX_W'(p),
                word_tab[p]};
        if (r.op == OP_REMOVE) begin
          last = packed_cnt - 1;
          // last entry fills the hole
          if (p != last) begin
            mover           = 32'(owner_tab[last]);
            link_tab[mover] = p;
            word_tab[p]     = word_tab[last];
            owner_tab[p]    = IDX_W'(mover);
          end
          packed_cnt  = last;
          gen_tab[s]  = gen_tab[s] + GEN_W'(1);
          link_tab[s] = free_top;
          occupied[s] = 1'b0;
          free_top    = s;
        end
      end
      default: begin
        p = 32'(r.dense_position);
        if (p >= packed_cnt) begin
          rsp.status = ST_OUT_RANGE;
          return rsp;
        end
        s   = 32'(owner_tab[p]);
        rsp = '{ST_OK, pool_tag_q, IDX_W'(s), gen_tab[s], r.dense_position, word_tab[p]};
      end
    endcase
    return rsp;
  endfunction

  // mostly live handles and positions, some near misses, the rest raw noise
  function automatic req_t random_req(input int ins_pct);
    req_t        r;
    int unsigned k;
    int unsigned p;
    int unsigned s;
    int unsigned b;
    r.op                = op_e'($urandom_range(3));
    r.handle_type       = TAG_W'($urandom);
    r.handle_index      = IDX_W'($urandom);
    r.handle_generation = GEN_W'($urandom);
    r.dense_position    = IDX_W'($urandom);
    r.has_object        = 1'($urandom);
    r.object_word       = $urandom;
    k = $urandom_range(99);
    if (k < ins_pct) begin
      r.op = OP_INSERT;
    end else if (k < 88 && packed_cnt != 0) begin
      p = $urandom_range(packed_cnt - 1);
      s = 32'(owner_tab[p]);
      case (k % 3)
        0:       r.op = OP_REMOVE;
        1:       r.op = OP_LOOKUP;
        default: r.op = OP_MAKE;
      endcase
      r.dense_position    = IDX_W'(p);
      r.handle_type       = pool_tag_q;
      r.handle_index      = IDX_W'(s);
      r.handle_generation = gen_tab[s];
      if ($urandom_range(9) == 0) begin
        b = $urandom_range(GEN_W - 1);
        case ($urandom_range(2))
          0:       r.handle_type[b]       = ~r.handle_type[b];
          1:       r.handle_generation[b] = ~r.handle_generation[b];
          default: r.handle_index         = IDX_W'($urandom);
        endcase
      end
    end
    return r;
  endfunction

  task automatic send_req(input req_t r, input logic fixed, input rsp_t fixed_rsp,
                          output rsp_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = pool_apply(r);
    rsp_due = {rsp_due, fixed ? fixed_rsp : predicted};
  endtask

  task automatic run_random(input int n, input int ins_pct);
    rsp_t p;
    repeat (n) send_req(random_req(ins_pct), 1'b0, R_NONE, p);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tag(input logic [TAG_W-1:0] tag);
    drain_and_settle();
    cfg_pool_tag_i <= tag;
    cfg_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    pool_tag_q = tag;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: response expected none actual %h", $time, out_rsp_o);
        mismatches++;
      end else begin
        want = rsp_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_rsp_o.status));
        check_field("out_type", 32'(want.out_type), 32'(out_rsp_o.out_type));
        check_field("out_slot", 32'(want.out_slot), 32'(out_rsp_o.out_slot));
        check_field("out_generation", 32'(want.out_generation),
                    32'(out_rsp_o.out_generation));
        check_field("out_position", 32'(want.out_position),
                    32'(out_rsp_o.out_position));
        check_field("out_data", want.out_data, out_rsp_o.out_data);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("generational_handle_pool_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_t r;
    rsp_t p;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].rsp, p);

    for (int ph = 0; ph < PHASE_N; ph++) begin
      case (ph)
        0:       write_tag('1);
        2:       write_tag('0);
        default: write_tag(TAG_W'($urandom));
      endcase
      send_idle_pct = SEND_IDLE[ph];
      stall_pct     = RECV_IDLE[ph];
      run_random(PHASE_ITEMS, INS_PCT[ph]);
    end

    // fill to capacity, then overflow
    send_idle_pct = 20;
    stall_pct     = 20;
    while (packed_cnt < SLOTS) send_req(random_req(100), 1'b0, R_NONE, p);
    repeat (3) send_req(random_req(100), 1'b0, R_NONE, p);
    run_random(150, 30);

    // one slot freed and taken again many times
    write_tag(TAG_W'($urandom));
    send_idle_pct = 0;
    stall_pct     = 0;
    if (packed_cnt == SLOTS) begin
      r                   = random_req(100);
      r.op                = OP_REMOVE;
      r.handle_type       = pool_tag_q;
      r.handle_index      = owner_tab[0];
      r.handle_generation = gen_tab[owner_tab[0]];
      send_req(r, 1'b0, R_NONE, p);
    end
    repeat (REUSE_PAIRS) begin
      send_req(random_req(100), 1'b0, R_NONE, p);
      r                   = random_req(100);
      r.op                = OP_REMOVE;
      r.handle_type       = p.out_type;
      r.handle_index      = p.out_slot;
      r.handle_generation = p.out_generation;
      send_req(r, 1'b0, R_NONE, p);
    end
    run_random(100, 30);

    drain_and_settle();
    if (mismatches == 0) begin
      $display("generational_handle_pool_unit regression: pass");
    end else begin
      $display("generational_handle_pool_unit regression: fail");
    end
    $finish;
  end

endmodule
